/* sv/rcfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radio command frame parser package
// Shared types, codes and the single-precision scaling helpers.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  typedef enum logic [2:0] {
    CLS_NONE = 3'd0,
    CLS_G    = 3'd1,
    CLS_S    = 3'd2,
    CLS_T    = 3'd3,
    CLS_M    = 3'd4
  } cls_t;

  localparam logic [1:0] KIND_GO   = 2'd0;
  localparam logic [1:0] KIND_MODE = 2'd1;
  localparam logic [1:0] KIND_GPS  = 2'd2;
  localparam logic [1:0] KIND_MOVE = 2'd3;

  // Direction operations for a manual move.
  typedef enum logic [2:0] {
    DIR_N = 3'd0,
    DIR_S = 3'd1,
    DIR_E = 3'd2,
    DIR_W = 3'd3,
    DIR_U = 3'd4,
    DIR_D = 3'd5
  } dir_t;

  // 8.98e-6f: sign 0, exponent 110, mantissa with hidden bit.
  localparam logic [7:0]  K_EXP = 8'd110;
  localparam logic [23:0] K_MAN = 24'h96A8CE;

  // Classified frame handed from the front to the back.
  typedef struct packed {
    logic        ok;
    logic [1:0]  kind;
    logic [9:0]  num;
    logic        go;
    logic [3:0]  mode;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] alt;
    logic        photo;
    logic        scale;   // manual N/S/E/W: product still to be formed
    dir_t        dir;
  } frame_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  kind;
    logic [9:0]  num;
    logic        go;
    logic [3:0]  mode;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] alt;
    logic        photo;
  } result_t;

  function automatic logic [3:0] hexv(input logic [7:0] c, output logic bad);
    logic [3:0] v;
    bad = 1'b0;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else bad = 1'b1;
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/rcfp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame front end
// Absorbs one character per transfer and classifies a finished frame.
// ----------------------------------------------------------------------------
module rcfp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           byte_i,
  input  wire                  last_i,
  output logic                 fr_valid,
  input  wire                  fr_ready,
  output rcfp_pkg::frame_t     fr
);
  import rcfp_pkg::*;

  logic [4:0]  pos_r;
  cls_t        cls_r;
  logic        idok_r;
  logic [9:0]  id_r;
  logic [31:0] acc_r;
  logic        hexok_r;
  logic [31:0] w0_r, w1_r, w2_r;
  logic [7:0]  sel_r, flag_r;
  logic        fv_r;
  frame_t      fr_r;

  logic        take;
  logic [4:0]  p;
  cls_t        cls_n;
  logic        idok_n, hexok_n;
  logic [9:0]  id_n;
  logic [31:0] acc_n, w0_n, w1_n, w2_n;
  logic [7:0]  sel_n, flag_n;
  logic        hbad;
  logic [3:0]  hv;
  frame_t      f;
  logic [4:0]  len;

  assign in_ready = !fv_r || fr_ready;
  assign take = in_valid && in_ready;
  assign p = pos_r;
  assign fr_valid = fv_r;
  assign fr = fr_r;

  always_comb begin
    cls_n = cls_r; idok_n = idok_r; id_n = id_r; acc_n = acc_r; hexok_n = hexok_r;
    w0_n = w0_r; w1_n = w1_r; w2_n = w2_r; sel_n = sel_r; flag_n = flag_r;
    hv = hexv(byte_i, hbad);
    if (p == 5'd0) begin
      case (byte_i)
        8'h47:   cls_n = CLS_G;
        8'h53:   cls_n = CLS_S;
        8'h54:   cls_n = CLS_T;
        8'h4D:   cls_n = CLS_M;
        default: cls_n = CLS_NONE;
      endcase
    end else if (p <= 5'd3) begin
      if (byte_i >= 8'h30 && byte_i <= 8'h39)
        id_n = 10'(id_r * 10'd10 + 10'(byte_i - 8'h30));
      else idok_n = 1'b0;
    end else if (cls_r == CLS_G || cls_r == CLS_S) begin
      if (p == 5'd4) flag_n = byte_i;
    end else if (cls_r == CLS_T) begin
      if (p <= 5'd27) begin
        if (hbad) hexok_n = 1'b0;
        acc_n = {acc_r[27:0], hv};
        if (p[2:0] == 3'd3) begin
          if (p == 5'd11) w0_n = acc_n;
          else if (p == 5'd19) w1_n = acc_n;
          else w2_n = acc_n;
          acc_n = '0;
        end
      end else if (p == 5'd28) flag_n = byte_i;
    end else if (cls_r == CLS_M) begin
      if (p == 5'd4) sel_n = byte_i;
      else if (p <= 5'd12) begin
        if (hbad) hexok_n = 1'b0;
        acc_n = {acc_r[27:0], hv};
        if (p == 5'd12) begin
          w0_n = acc_n;
          acc_n = '0;
        end
      end
    end
  end

  always_comb begin
    len = (pos_r == 5'd31) ? 5'd31 : 5'(pos_r + 5'd1);
    f = '0;
    f.dir = DIR_N;
    f.num = id_n;
    f.ok = idok_n;
    case (cls_n)
      CLS_G: begin
        f.kind = KIND_GO;
        f.go = flag_n[0];
        if (len != 5'd5 || (flag_n != 8'h30 && flag_n != 8'h31)) f.ok = 1'b0;
      end
      CLS_S: begin
        f.kind = KIND_MODE;
        if (flag_n >= 8'h30 && flag_n <= 8'h39) f.mode = 4'(flag_n - 8'h30);
        else if (flag_n == 8'h41) f.mode = 4'd10;
        else f.ok = 1'b0;
        if (len != 5'd5) f.ok = 1'b0;
      end
      CLS_T: begin
        f.kind = KIND_GPS;
        f.lat = w0_n; f.lon = w1_n; f.alt = w2_n;
        f.photo = flag_n[0];
        if (len != 5'd29 || !hexok_n || (flag_n != 8'h30 && flag_n != 8'h31))
          f.ok = 1'b0;
      end
      CLS_M: begin
        f.kind = KIND_MOVE;
        f.lat = w0_n;
        f.scale = 1'b1;
        case (sel_n)
          8'h4E: f.dir = DIR_N;
          8'h53: f.dir = DIR_S;
          8'h45: f.dir = DIR_E;
          8'h57: f.dir = DIR_W;
          8'h55: begin f.dir = DIR_U; f.scale = 1'b0; f.lat = '0; f.alt = w0_n; end
          8'h44: begin
            f.dir = DIR_D; f.scale = 1'b0; f.lat = '0; f.alt = {~w0_n[31], w0_n[30:0]};
          end
          default: f.ok = 1'b0;
        endcase
        if (len != 5'd13 || !hexok_n) f.ok = 1'b0;
      end
      default: f.ok = 1'b0;
    endcase
    if (!f.ok) f = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
      pos_r <= '0; cls_r <= CLS_NONE; idok_r <= 1'b1; id_r <= '0; acc_r <= '0;
      hexok_r <= 1'b1; w0_r <= '0; w1_r <= '0; w2_r <= '0; sel_r <= '0; flag_r <= '0;
    end else begin
      if (take && last_i) fv_r <= 1'b1;
      else if (fr_ready) fv_r <= 1'b0;
      if (take) begin
        if (last_i) begin
          fr_r <= f;
          pos_r <= '0; cls_r <= CLS_NONE; idok_r <= 1'b1; id_r <= '0; acc_r <= '0;
          hexok_r <= 1'b1; w0_r <= '0; w1_r <= '0; w2_r <= '0; sel_r <= '0;
          flag_r <= '0;
        end else begin
          pos_r <= (pos_r == 5'd31) ? pos_r : 5'(pos_r + 5'd1);
          cls_r <= cls_n; idok_r <= idok_n; id_r <= id_n; acc_r <= acc_n;
          hexok_r <= hexok_n; w0_r <= w0_n; w1_r <= w1_n; w2_r <= w2_n;
          sel_r <= sel_n; flag_r <= flag_n;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/rcfp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rcfp_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_valid,
  output logic              wr_ready,
  input  rcfp_pkg::frame_t  wr_data,
  output logic              rd_valid,
  input  wire               rd_ready,
  output rcfp_pkg::frame_t  rd_data
);
  import rcfp_pkg::*;

  frame_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, wr} - {1'b0, rd});
    end
  end
endmodule
`default_nettype wire

/* sv/rcfp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame back end
// Forms the scaled distance with a two-stage float multiply and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module rcfp_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                fr_valid,
  output logic               fr_ready,
  input  rcfp_pkg::frame_t   fr,
  output logic               out_valid,
  input  wire                out_ready,
  output rcfp_pkg::result_t  res
);
  import rcfp_pkg::*;

  // Stage 1: mantissa product and exponent prep.
  logic        v1_r;
  frame_t      f1_r;
  logic [47:0] prod_r;
  logic [9:0]  e1_r;     // biased sum exponent, offset by +128
  logic        nan1_r, inf1_r, zero1_r;
  logic [31:0] d1_r;
  // Stage 2 output.
  logic        v2_r;
  result_t     res_r;

  logic        adv1, adv2;
  logic [31:0] d;
  logic [7:0]  de;
  logic [22:0] dm;
  logic [23:0] ma;
  logic [5:0]  lz;
  logic        found;
  logic        sub;

  assign adv2 = !v2_r || out_ready;
  assign adv1 = !v1_r || adv2;
  assign fr_ready = adv1;
  assign out_valid = v2_r;
  assign res = res_r;

  assign d = fr.lat;
  assign de = d[30:23];
  assign dm = d[22:0];
  assign sub = (de == 8'd0);

  always_comb begin
    ma = sub ? {1'b0, dm} : {1'b1, dm};
    lz = 6'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (ma[i] && !found) begin
        lz = 6'(23 - i);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_r <= fr;
      d1_r <= d;
      prod_r <= 48'(ma << lz) * 48'(K_MAN);
      // unbiased: (de or 1) - 127 - lz + (110 - 127) ; stored + 127 + 128
      e1_r <= 10'(({2'b0, (sub ? 8'd1 : de)}) + 10'd128 - 10'd127 + {2'b0, K_EXP}
              - {4'b0, lz});
      nan1_r <= (de == 8'hFF) && (dm != '0);
      inf1_r <= (de == 8'hFF) && (dm == '0);
      zero1_r <= sub && (dm == '0);
    end
  end

  // Stage 2: normalize, round to nearest even, pack.
  logic [47:0] pn;
  logic [10:0] en;         // exponent + 128
  logic [72:0] sh;
  logic [23:0] mk;
  logic        g, st, rnd;
  logic [24:0] mr;
  logic [10:0] ef;
  logic [31:0] mag;
  logic [5:0]  ds;
  result_t     r;

  always_comb begin
    if (prod_r[47]) begin
      pn = prod_r; en = {1'b0, e1_r} + 11'd1;
    end else begin
      pn = {prod_r[46:0], 1'b0}; en = {1'b0, e1_r};
    end
    // en-128 is the biased result exponent; below 1 it is subnormal.
    ds = 6'd0;
    if (en < 11'd129) ds = (11'd129 - en > 11'd26) ? 6'd26 : 6'(11'd129 - en);
    sh = {pn, 25'd0} >> ds;
    mk = sh[72:49];
    g = sh[48];
    st = |sh[47:0];
    rnd = g && (st || mk[0]);
    mr = {1'b0, mk} + {24'd0, rnd};
    // A subnormal that rounds up to the hidden bit becomes the smallest normal.
    ef = (ds != 6'd0) ? 11'd129 : en;
    if (mr[24]) begin
      ef = 11'(ef + 11'd1);
      mr = mr >> 1;
    end
    if (ds != 6'd0 && !mr[23]) mag = {1'b0, 8'd0, mr[22:0]};
    else if (ef >= 11'd383) mag = {1'b0, 8'hFF, 23'd0};
    else mag = {1'b0, 8'(ef - 11'd128), mr[22:0]};
    if (nan1_r) mag = {1'b0, d1_r[30:0]} | 32'h0040_0000;
    else if (inf1_r) mag = {1'b0, 8'hFF, 23'd0};
    else if (zero1_r) mag = '0;
    if (!nan1_r) mag[31] = d1_r[31];
    else mag[31] = d1_r[31];

    r.ok = f1_r.ok; r.kind = f1_r.kind; r.num = f1_r.num; r.go = f1_r.go;
    r.mode = f1_r.mode; r.lat = f1_r.lat; r.lon = f1_r.lon; r.alt = f1_r.alt;
    r.photo = f1_r.photo;
    if (f1_r.scale) begin
      r.lat = '0; r.lon = '0;
      case (f1_r.dir)
        DIR_N:   r.lat = mag;
        DIR_S:   r.lat = {~mag[31], mag[30:0]};
        DIR_E:   r.lon = mag;
        DIR_W:   r.lon = {~mag[31], mag[30:0]};
        default: r.lat = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) res_r <= r;
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= fr_valid;
      if (adv2) v2_r <= v1_r;
    end
  end
endmodule
`default_nettype wire

/* sv/radio_command_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radio command frame parser
// Parses ASCII command frames into decoded commands.
// ----------------------------------------------------------------------------
// Input transfers carry one message character each in in_tdata and mark the
// final character with in_tlast. One transfer is taken every cycle while
// in_tready is high. On the final character the front end classifies the
// whole frame (opcode, ID digits, hex words, flag, mode or direction) and
// pushes it into a two-entry queue. The back end forms the scaled distance of
// a manual move with a two-stage single-precision multiply (round to nearest
// even). Each frame gives exactly one result transfer; a rejected frame gives
// accepted=0 with all other fields zero. While in_tready is high, throughput
// is one character per cycle, and one frame per cycle for single-character
// frames, set by the front end taking one character a cycle.
// When the receiver holds out_tready low, results pile up in the back end and
// the queue, and in_tready falls only once all of them are full.
// A synchronous active-low reset clears all parse state and empties the
// queue and pipeline; no result is pending afterwards.
// ----------------------------------------------------------------------------
module radio_command_frame_parser (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,   // message_byte
  input  wire          in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  wire          out_tready,
  // [0] accepted, [2:1] command_kind, [12:3] command_number, [13] go_flag,
  // [17:14] new_mode, [49:18] lat_word, [81:50] lon_word, [113:82] alt_word,
  // [114] photo_flag, [119:115] zero
  output logic [119:0] out_tdata
);
  import rcfp_pkg::*;

  frame_t  ff, qf;
  logic    fv, fr, qv, qr;
  result_t r;

  rcfp_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .byte_i(in_tdata),
    .last_i(in_tlast), .fr_valid(fv), .fr_ready(fr), .fr(ff)
  );

  rcfp_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(ff),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qf)
  );

  rcfp_back u_back (
    .clk, .rst_n, .fr_valid(qv), .fr_ready(qr), .fr(qf),
    .out_valid(out_tvalid), .out_ready(out_tready), .res(r)
  );

  assign out_tdata = {5'd0, r.photo, r.alt, r.lon, r.lat, r.mode, r.go, r.num,
                      r.kind, r.ok};
endmodule
`default_nettype wire

/* sv/rcfp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radio command frame parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module rcfp_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [119:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[119:1] == '0)
    else $error("rejected result carries data");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[119:115] == '0)
    else $error("padding not zero");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid}))
    else $error("handshake output unknown");
endmodule

bind radio_command_frame_parser rcfp_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

/* tb/sv/radio_command_frame_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radio command frame parser testbench
// Drives ASCII command messages into the parser and checks every decoded
// command against an in-bench decoder, including the scaled manual moves.
// ----------------------------------------------------------------------------
// Each test task builds whole messages in a byte queue and streams them in,
// one character per input transfer, with in_tlast on the final character.
// When a final character is accepted, the decoder works out the command that
// the message should give and queues it. A separate process pops the oldest
// queued command for each output transfer and compares it field by field.
// Both sides idle at random, except during a calm stretch, and one test holds
// the output off long enough that the parser has to stall its input.
// ----------------------------------------------------------------------------
module radio_command_frame_parser_test;
  import rcfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic        accepted;
    logic [1:0]  kind;
    logic [9:0]  number;
    logic        go;
    logic [3:0]  mode;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] alt;
    logic        photo;
  } command_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;   // message_byte
  logic         in_tlast = 1'b0;    // end_of_message
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [0] accepted, [2:1] command_kind, [12:3] command_number, [13] go_flag,
  // [17:14] new_mode, [49:18] lat_word, [81:50] lon_word, [113:82] alt_word,
  // [114] photo_flag, [119:115] zero
  logic [119:0] out_tdata;

  // Commands still owed by the parser, oldest first.
  command_t pending_commands[$];
  // Characters of the message being built and of the one being streamed.
  logic [7:0] message[$];
  logic [7:0] received_chars[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;        // no idling on either side while set
  int         hold_request = 0;   // cycles for the receiver to hold off

  radio_command_frame_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("radio_command_frame_parser_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Decoder
  // --------------------------------------------------------------------------
  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Distance times 8.98e-6 in single precision, round to nearest even.
  // The product of the two 24-bit significands is normalized and rounded in
  // integer arithmetic; results below the normal range round as subnormals.
  function automatic logic [31:0] scaled_distance(input logic [31:0] d,
                                                  input bit negate);
    logic [31:0] r;
    logic [23:0] sig;
    logic [47:0] prod;
    logic [47:0] q;
    logic [47:0] rem;
    logic [47:0] half;
    int          msb;
    int          ea;
    int          bexp;
    int          sh;
    int          kexp;
    kexp = int'(K_EXP);
    if (d[30:23] == 8'hFF && d[22:0] != 0) begin
      r = d | 32'h0040_0000;                 // NaN comes back quiet
    end else if (d[30:23] == 8'hFF) begin
      r = {d[31], 31'h7F80_0000};             // infinity stays infinite
    end else if (d[30:0] == 0) begin
      r = {d[31], 31'h0};
    end else begin
      sig  = (d[30:23] != 0) ? {1'b1, d[22:0]} : {1'b0, d[22:0]};
      ea   = (d[30:23] != 0) ? int'(d[30:23]) : 1;
      prod = 48'(sig) * 48'(K_MAN);
      msb  = 0;
      for (int i = 0; i < 48; i++) if (prod[i]) msb = i;
      bexp = msb + ea + kexp - 173;
      sh   = (bexp >= 1) ? msb - 23 : 151 - kexp - ea;
      q    = prod >> sh;
      rem  = prod & ((48'd1 << sh) - 48'd1);
      half = (sh > 0) ? (48'd1 << (sh - 1)) : 48'd0;
      if (sh > 0 && (rem > half || (rem == half && q[0]))) q = q + 48'd1;
      // A rounding carry moves naturally into the exponent field.
      if (bexp >= 1) r = {d[31], 31'((bexp - 1) << 23) + 31'(q)};
      else           r = {d[31], 31'(q)};
    end
    return negate ? (r ^ 32'h8000_0000) : r;
  endfunction

  // Reads one 8-digit hex word starting at position pos; ok falls on a bad digit.
  function automatic logic [31:0] hex_word_at(input logic [7:0] m[$], input int pos,
                                              inout bit ok);
    logic [31:0] w;
    int          v;
    w = 0;
    for (int i = 0; i < 8; i++) begin
      v = hex_digit_value(m[pos + i]);
      if (v < 0) begin
        ok = 1'b0;
        v = 0;
      end
      w = (w << 4) | 32'(v);
    end
    return w;
  endfunction

  // Works out the command that one complete message should give.
  function automatic command_t decode_message(input logic [7:0] m[$]);
    command_t    c;
    command_t    none;
    int          len;
    bit          ok;
    logic [7:0]  flag;
    logic [31:0] distance_word;
    none = '{default: '0};
    c    = none;
    len  = (m.size() > 31) ? 31 : m.size();
    ok   = 1'b1;
    for (int i = 1; i <= 3; i++) begin
      if (i < m.size()) begin
        if (m[i] >= "0" && m[i] <= "9") c.number = 10'(c.number * 10 + (m[i] - "0"));
        else ok = 1'b0;
      end
    end
    if (!ok) return none;
    case (m[0])
      "G": begin
        if (len != 5 || (m[4] != "0" && m[4] != "1")) return none;
        c.kind = KIND_GO;
        c.go   = m[4][0];
      end
      "S": begin
        if (len != 5) return none;
        flag = m[4];
        if (flag >= "0" && flag <= "9") c.mode = 4'(flag - "0");
        else if (flag == "A") c.mode = 4'd10;
        else return none;
        c.kind = KIND_MODE;
      end
      "T": begin
        if (len != 29) return none;
        c.lat = hex_word_at(m, 4, ok);
        c.lon = hex_word_at(m, 12, ok);
        c.alt = hex_word_at(m, 20, ok);
        if (!ok || (m[28] != "0" && m[28] != "1")) return none;
        c.kind  = KIND_GPS;
        c.photo = m[28][0];
      end
      "M": begin
        if (len != 13) return none;
        distance_word = hex_word_at(m, 5, ok);
        if (!ok) return none;
        case (m[4])
          "N": c.lat = scaled_distance(distance_word, 1'b0);
          "S": c.lat = scaled_distance(distance_word, 1'b1);
          "E": c.lon = scaled_distance(distance_word, 1'b0);
          "W": c.lon = scaled_distance(distance_word, 1'b1);
          "U": c.alt = distance_word;
          "D": c.alt = distance_word ^ 32'h8000_0000;
          default: return none;
        endcase
        c.kind = KIND_MOVE;
      end
      default: return none;
    endcase
    c.accepted = 1'b1;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Message building helpers
  // --------------------------------------------------------------------------
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) message.push_back(s[i]);
  endfunction

  function automatic void add_hex_word(input logic [31:0] w, input bit lower);
    logic [3:0] nib;
    for (int i = 7; i >= 0; i--) begin
      nib = w[i*4 +: 4];
      if (nib < 10) message.push_back(8'("0") + 8'(nib));
      else message.push_back((lower ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic void add_id(input int id);
    message.push_back(8'("0") + 8'(id / 100));
    message.push_back(8'("0") + 8'((id / 10) % 10));
    message.push_back(8'("0") + 8'(id % 10));
  endfunction

  // --------------------------------------------------------------------------
  // Sender: streams the built message, one transfer per character.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input bit last);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    received_chars.push_back(c);
    if (last) begin
      pending_commands.push_back(decode_message(received_chars));
      received_chars.delete();
    end
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < message.size(); i++) send_char(message[i], i == message.size() - 1);
    message.delete();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random idling, or a long hold-off when a test asks for one.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Checks each output transfer against the oldest pending command.
  always @(posedge clk) begin
    command_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_commands.size() == 0) begin
        $error("unexpected result transfer: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_commands.pop_front();
        if (out_tdata[0] !== want.accepted) begin
          $error("accepted: expected %h, got %h", want.accepted, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[2:1] !== want.kind) begin
          $error("command_kind: expected %h, got %h", want.kind, out_tdata[2:1]);
          error_count++;
        end
        if (out_tdata[12:3] !== want.number) begin
          $error("command_number: expected %0d, got %0d", want.number, out_tdata[12:3]);
          error_count++;
        end
        if (out_tdata[13] !== want.go) begin
          $error("go_flag: expected %h, got %h", want.go, out_tdata[13]);
          error_count++;
        end
        if (out_tdata[17:14] !== want.mode) begin
          $error("new_mode: expected %h, got %h", want.mode, out_tdata[17:14]);
          error_count++;
        end
        if (out_tdata[49:18] !== want.lat) begin
          $error("lat_word: expected %h, got %h", want.lat, out_tdata[49:18]);
          error_count++;
        end
        if (out_tdata[81:50] !== want.lon) begin
          $error("lon_word: expected %h, got %h", want.lon, out_tdata[81:50]);
          error_count++;
        end
        if (out_tdata[113:82] !== want.alt) begin
          $error("alt_word: expected %h, got %h", want.alt, out_tdata[113:82]);
          error_count++;
        end
        if (out_tdata[114] !== want.photo) begin
          $error("photo_flag: expected %h, got %h", want.photo, out_tdata[114]);
          error_count++;
        end
        if (out_tdata[119:115] !== 5'd0) begin
          $error("pad bits: expected 0, got %h", out_tdata[119:115]);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Go flags and mode changes, including the highest mode and bad characters.
  task automatic test_go_and_mode();
    add_text("G0000"); send_message();
    add_text("G9991"); send_message();
    add_text("G1232"); send_message();
    add_text("S0420"); send_message();
    add_text("S5559"); send_message();
    add_text("S007A"); send_message();
    add_text("S007a"); send_message();
  endtask

  // GPS targets with both cases of hex digits and both photo flags.
  task automatic test_gps_target();
    add_text("T314"); add_hex_word(32'h41C8_0000, 1'b0); add_hex_word(32'hC2F6_E979, 1'b1);
    add_hex_word(32'hFFFF_FFFF, 1'b0); add_text("1"); send_message();
    add_text("T000"); add_hex_word(32'h0, 1'b1); add_hex_word(32'hABCD_EF01, 1'b1);
    add_hex_word(32'h1234_5678, 1'b0); add_text("0"); send_message();
    // A non-hex character in the middle word.
    add_text("T001"); add_hex_word(32'h1, 1'b0); add_text("0000g000");
    add_hex_word(32'h2, 1'b0); add_text("1"); send_message();
  endtask

  // Manual moves in all six directions, a quiet and a signaling NaN, a bad letter.
  task automatic test_manual_move();
    string dirs;
    dirs = "NSEWUD";
    for (int i = 0; i < 6; i++) begin
      add_text("M100"); message.push_back(dirs[i]);
      add_hex_word(32'h4120_0000 + 32'(i * 32'h0012_3457), i[0]); send_message();
    end
    add_text("M101N"); add_hex_word(32'h7F80_0001, 1'b0); send_message();
    add_text("M102W"); add_hex_word(32'hFFC0_1234, 1'b0); send_message();
    add_text("M103Q"); add_hex_word(32'h3F80_0000, 1'b0); send_message();
  endtask

  // Unknown opcode, bad ID digit, a single character, wrong and over-long lengths.
  task automatic test_malformed();
    add_text("X1231"); send_message();
    add_text("G1a31"); send_message();
    add_text("G"); send_message();
    add_text("G12310"); send_message();
    add_text("M200N"); add_hex_word(32'h3F80_0000, 1'b0); add_text("0"); send_message();
    for (int i = 0; i < 35; i++) message.push_back(i < 29 ? 8'("T") : 8'($urandom_range(0, 255)));
    send_message();
  endtask

  // Holds the receiver off while short messages keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_request = 150;
    for (int i = 0; i < 10; i++) begin
      add_text("G"); add_id($urandom_range(0, 999)); add_text("1"); send_message();
    end
  endtask

  function automatic logic [31:0] random_distance();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'b0, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      5: return 32'h0000_0001;
      6: return 32'h007F_FFFF;
      7: return 32'h7F7F_FFFF;
      8: return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 40)), 23'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // Builds one random message: mostly well-formed, some noise, some broken.
  function automatic void build_random_message();
    string flags;
    string dirs;
    int    pick;
    flags = "0123456789A";
    dirs  = "NSEWUD";
    pick  = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 35)) message.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 3))
      0: message.push_back("G");
      1: message.push_back("S");
      2: message.push_back("T");
      default: message.push_back("M");
    endcase
    add_id($urandom_range(0, 999));
    if ($urandom_range(0, 19) == 0) message[$urandom_range(1, 3)] = 8'($urandom_range(0, 255));
    case (message[0])
      "G": message.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                       : 8'("0") + 8'($urandom_range(0, 1)));
      "S": message.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                       : flags[$urandom_range(0, 10)]);
      "T": begin
        repeat (3) add_hex_word($urandom(), $urandom_range(0, 1));
        message.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                    : 8'("0") + 8'($urandom_range(0, 1)));
      end
      default: begin
        message.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                    : dirs[$urandom_range(0, 5)]);
        add_hex_word(random_distance(), $urandom_range(0, 1));
      end
    endcase
    case ($urandom_range(0, 19))
      0: void'(message.pop_back());
      1: message.push_back(8'($urandom_range(0, 255)));
      2: message[$urandom_range(4, message.size() - 1)] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endfunction

  // Random traffic; the first stretch runs with no idling on either side.
  task automatic test_random_traffic();
    int sent;
    sent = 0;
    calm = 1'b1;
    while (sent < 60) begin
      if (sent > 30) calm = 1'b0;
      build_random_message();
      sent += message.size();
      send_message();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_go_and_mode();
    test_gps_target();
    test_manual_move();
    test_malformed();
    test_backpressure();
    test_random_traffic();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("radio_command_frame_parser_test OK");
    end else begin
      $display("radio_command_frame_parser_test NOT OK");
    end
    $finish;
  end

endmodule
